### rtl/tevq_pkg.sv
`default_nettype none

package tevq_pkg;

   // Queue geometry
   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths
   localparam int FUNC_W = 2;
   localparam int KIND_W = 4;
   localparam int DUE_W  = 32;
   localparam int OCC_W  = 5;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_FIELDS_W = KIND_W + 3 * DUE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_PAD_W    = REQ_DATA_W - REQ_FIELDS_W;
   localparam int RSP_FIELDS_W = DUE_W + 1 + KIND_W + DUE_W + OCC_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT    = 2'd0,
      FUNC_CANCEL    = 2'd1,
      FUNC_QUERY     = 2'd2,
      FUNC_FRAME_END = 2'd3
   } func_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DUE_W-1:0]  due;
   } slot_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type         wr_data;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [DUE_W-1:0] diff;
      logic             gt;
   } alu_res_type;

endpackage

`default_nettype wire

### rtl/timed_event_queue_core.sv
`default_nettype none

// Sorted timer event queue. Holds up to DEPTH pending events (4-bit kind,
// 32-bit due cycle) in a slot memory, earliest first, equal due cycles in
// arrival order. A request (func in req_tuser) inserts an event in front of
// the first strictly later one, cancels every event of a kind, queries the
// cycles left until the first event of a kind (due minus now, wrapped, 0 if
// none) or ends a frame by subtracting the elapsed cycles from every due
// cycle with 32-bit wrap. Every response carries a drop flag (rsp_tuser,
// insert into a full queue), the query answer, the head event and the
// occupancy. From acceptance to the response register a request passes through
// an accept state, a state that primes the slot memory read, a walk over every
// pending slot plus a closing step, and the FIN and HEAD states that read back
// the head slot; an insert into a full queue skips the priming and the walk.
// The walk is set by the slot memory with one registered read port and one
// write port, and the one shared subtract/compare unit that insert, query and
// frame-end steps go through. The block takes no request while a walk runs; a
// finished response waits in the output register, and the next request is
// taken meanwhile.

module timed_event_queue_core (
   input  wire                             clock,
   input  wire                             reset,
   // request channel
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // [3:0] event_kind, [35:4] due_cycle, [67:36] now_cycle,
   // [99:68] elapsed_cycles, [103:100] zero
   input  wire  [tevq_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire  [tevq_pkg::FUNC_W-1:0]     req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // [31:0] remaining, [32] head_valid, [36:33] head_kind,
   // [68:37] head_due, [73:69] occupancy, [79:74] zero
   output logic [tevq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] status
   output logic                            rsp_tuser
);
   import tevq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_WALK,
      ST_FIN,
      ST_HEAD
   } state_type;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [DUE_W-1:0]  opnd_ff, opnd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              found_ff, found_in;
   slot_type          carry_ff, carry_in;
   logic              status_ff, status_in;
   logic [DUE_W-1:0]  remaining_ff, remaining_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [DUE_W-1:0]  rsp_remaining_ff, rsp_remaining_in;
   logic              rsp_hv_ff, rsp_hv_in;
   logic [KIND_W-1:0] rsp_hk_ff, rsp_hk_in;
   logic [DUE_W-1:0]  rsp_hd_ff, rsp_hd_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   ram_req_type       ram_req;
   slot_type          rd_data;
   alu_res_type       alu_res;
   logic [CNT_W-1:0]  ptr_nxt;
   logic [CNT_W-1:0]  wr_ptr_nxt;
   logic              at_end;
   logic              load;

   tevq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // Shared unit: slot due against the request operand
   tevq_alu u_alu (
      .opa (rd_data.due),
      .opb (opnd_ff),
      .res (alu_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign ptr_nxt    = ptr_ff + CNT_W'(1);
   assign wr_ptr_nxt = wr_ptr_ff + CNT_W'(1);
   assign at_end     = (ptr_ff == count_ff);
   // Move the finished request into the output register once it is free
   assign load       = (state_ff == ST_HEAD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in         = state_ff;
      func_in          = func_ff;
      kind_in          = kind_ff;
      opnd_in          = opnd_ff;
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      wr_ptr_in        = wr_ptr_ff;
      found_in         = found_ff;
      carry_in         = carry_ff;
      status_in        = status_ff;
      remaining_in     = remaining_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_remaining_in = rsp_remaining_ff;
      rsp_hv_in        = rsp_hv_ff;
      rsp_hk_in        = rsp_hk_ff;
      rsp_hd_in        = rsp_hd_ff;
      rsp_occ_in       = rsp_occ_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      ram_req          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // Latch the request; keep only the operand this func needs
               func_in      = func_type'(req_tuser);
               kind_in      = req_tdata[KIND_W-1:0];
               ptr_in       = '0;
               wr_ptr_in    = '0;
               found_in     = 1'b0;
               status_in    = 1'b0;
               remaining_in = '0;
               case (func_type'(req_tuser))
                  FUNC_QUERY:     opnd_in = req_tdata[KIND_W+2*DUE_W-1 -: DUE_W];
                  FUNC_FRAME_END: opnd_in = req_tdata[KIND_W+3*DUE_W-1 -: DUE_W];
                  default:        opnd_in = req_tdata[KIND_W+DUE_W-1 -: DUE_W];
               endcase
               if ((func_type'(req_tuser) == FUNC_INSERT) && (count_ff == CNT_W'(DEPTH))) begin
                  // Drop the insert, flag it, leave the list alone
                  status_in = 1'b1;
                  state_in  = ST_FIN;
               end else begin
                  state_in  = ST_PRIME;
               end
            end
         end

         ST_PRIME: begin
            ram_req.rd_addr = '0;
            state_in        = ST_WALK;
         end

         ST_WALK: begin
            // rd_data holds slot ptr_ff; fetch the next one meanwhile
            ram_req.rd_addr = ptr_nxt[IDX_W-1:0];
            if (at_end) begin
               state_in = ST_FIN;
               case (func_ff)
                  FUNC_INSERT: begin
                     // Append the displaced tail slot, or the new event itself
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = ptr_ff[IDX_W-1:0];
                     ram_req.wr_data = found_ff ? carry_ff : slot_type'{kind_ff, opnd_ff};
                     count_in        = count_ff + CNT_W'(1);
                  end
                  FUNC_CANCEL: begin
                     count_in = wr_ptr_ff;
                  end
                  default: begin
                  end
               endcase
            end else begin
               ptr_in = ptr_nxt;
               case (func_ff)
                  FUNC_INSERT: begin
                     if (found_ff) begin
                        // Shift: drop the carried slot here, carry this one on
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = ptr_ff[IDX_W-1:0];
                        ram_req.wr_data = carry_ff;
                        carry_in        = rd_data;
                     end else if (alu_res.gt) begin
                        // First strictly later slot: place the new event here
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = ptr_ff[IDX_W-1:0];
                        ram_req.wr_data = slot_type'{kind_ff, opnd_ff};
                        carry_in        = rd_data;
                        found_in        = 1'b1;
                     end
                  end
                  FUNC_CANCEL: begin
                     // Compact the survivors toward the head
                     if (rd_data.kind != kind_ff) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = wr_ptr_ff[IDX_W-1:0];
                        ram_req.wr_data = rd_data;
                        wr_ptr_in       = wr_ptr_nxt;
                     end
                  end
                  FUNC_QUERY: begin
                     if (!found_ff && (rd_data.kind == kind_ff)) begin
                        remaining_in = alu_res.diff;
                        found_in     = 1'b1;
                     end
                  end
                  FUNC_FRAME_END: begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = ptr_ff[IDX_W-1:0];
                     ram_req.wr_data = slot_type'{rd_data.kind, alu_res.diff};
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_FIN: begin
            // All writes are done; read back the head slot
            ram_req.rd_addr = '0;
            state_in        = ST_HEAD;
         end

         ST_HEAD: begin
            ram_req.rd_addr = '0;
            if (load) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = status_ff;
               rsp_remaining_in = remaining_ff;
               rsp_hv_in        = (count_ff != '0);
               rsp_hk_in        = (count_ff != '0) ? rd_data.kind : '0;
               rsp_hd_in        = (count_ff != '0) ? rd_data.due : '0;
               rsp_occ_in       = OCC_W'(count_ff);
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff          <= func_in;
      kind_ff          <= kind_in;
      opnd_ff          <= opnd_in;
      ptr_ff           <= ptr_in;
      wr_ptr_ff        <= wr_ptr_in;
      found_ff         <= found_in;
      carry_ff         <= carry_in;
      status_ff        <= status_in;
      remaining_ff     <= remaining_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_remaining_ff <= rsp_remaining_in;
      rsp_hv_ff        <= rsp_hv_in;
      rsp_hk_ff        <= rsp_hk_in;
      rsp_hd_ff        <= rsp_hd_in;
      rsp_occ_ff       <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_occ_ff, rsp_hd_ff, rsp_hk_ff,
                        rsp_hv_ff, rsp_remaining_ff};

   // Occupancy never exceeds the slot count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   // A dropped insert is only reported when the queue is full
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (load && status_ff) |-> (count_ff == CNT_W'(DEPTH)))
      else $error("insert dropped on a queue that is not full");

   // The walk stays inside the list and compaction never passes the read pointer
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((ptr_ff <= count_ff) && (wr_ptr_ff <= ptr_ff)))
      else $error("walk pointer out of range");

   // A response only appears out of the head readback
   a_rsp_from_head: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_HEAD))
      else $error("response raised outside head readback");

endmodule

`default_nettype wire

### rtl/tevq_ram.sv
`default_nettype none

module tevq_ram (
   input  wire                    clock,
   input  tevq_pkg::ram_req_type  ram_req,
   output tevq_pkg::slot_type     rd_data
);
   import tevq_pkg::*;

   slot_type slot_mem_ff [DEPTH];
   slot_type rd_data_ff;

   // One write port, one registered read port; read returns old data on a collision
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         slot_mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= slot_mem_ff[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/tevq_alu.sv
`default_nettype none

module tevq_alu (
   input  wire [tevq_pkg::DUE_W-1:0] opa,
   input  wire [tevq_pkg::DUE_W-1:0] opb,
   output tevq_pkg::alu_res_type     res
);
   import tevq_pkg::*;

   logic [DUE_W:0] sub;

   // One subtractor: wrapped difference, and a > b from borrow and zero test
   always_comb begin
      sub      = {1'b0, opa} - {1'b0, opb};
      res.diff = sub[DUE_W-1:0];
      res.gt   = !sub[DUE_W] && (sub[DUE_W-1:0] != '0);
   end

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
   import tevq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 340;
   localparam int MAX_REPORTS = 10;

   // One response as the block reports it: status first, then the rsp_tdata fields from the low bit up
   typedef struct packed {
      logic             status;
      logic [DUE_W-1:0] remaining;
      logic             head_valid;
      logic [KIND_W-1:0] head_kind;
      logic [DUE_W-1:0] head_due;
      logic [OCC_W-1:0] occupancy;
   } queue_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire                   rsp_tuser;

   // Shadow copy of the event list, earliest first
   logic [KIND_W-1:0] sched_kind [DEPTH];
   logic [DUE_W-1:0]  sched_due  [DEPTH];
   int                sched_count = 0;

   queue_report_type reports_in_flight [$];

   int mismatches    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_left = 0;

   timed_event_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one accepted request to the shadow list and queue the response it must produce.
   function automatic void apply_to_schedule(func_type op, logic [KIND_W-1:0] kind,
                                             logic [DUE_W-1:0] due, logic [DUE_W-1:0] now,
                                             logic [DUE_W-1:0] elapsed);
      queue_report_type r;
      int               pos;
      int               w;
      int               i;
      bit               found;
      r = '0;
      found = 1'b0;
      case (op)
         FUNC_INSERT: begin
            if (sched_count >= DEPTH) begin
               // full queue: drop the event, flag it
               r.status = 1'b1;
            end else begin
               // place in front of the first strictly later due cycle
               pos = 0;
               while (pos < sched_count && sched_due[pos] <= due) pos++;
               for (i = sched_count; i > pos; i--) begin
                  sched_kind[i] = sched_kind[i-1];
                  sched_due[i]  = sched_due[i-1];
               end
               sched_kind[pos] = kind;
               sched_due[pos]  = due;
               sched_count++;
            end
         end
         FUNC_CANCEL: begin
            w = 0;
            for (i = 0; i < sched_count; i++) begin
               if (sched_kind[i] != kind) begin
                  sched_kind[w] = sched_kind[i];
                  sched_due[w]  = sched_due[i];
                  w++;
               end
            end
            sched_count = w;
         end
         FUNC_QUERY: begin
            for (i = 0; i < sched_count; i++) begin
               if (!found && sched_kind[i] == kind) begin
                  r.remaining = sched_due[i] - now;
                  found = 1'b1;
               end
            end
         end
         default: begin
            // frame end: wrap every due cycle, keep list order
            for (i = 0; i < sched_count; i++) sched_due[i] = sched_due[i] - elapsed;
         end
      endcase
      if (sched_count > 0) begin
         r.head_valid = 1'b1;
         r.head_kind  = sched_kind[0];
         r.head_due   = sched_due[0];
      end
      r.occupancy = OCC_W'(sched_count);
      reports_in_flight.push_back(r);
   endfunction

   // Send one request: idle at random, hold valid until accepted, then predict.
   task automatic send_request(func_type op, logic [KIND_W-1:0] kind, logic [DUE_W-1:0] due,
                               logic [DUE_W-1:0] now, logic [DUE_W-1:0] elapsed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, elapsed, now, due, kind};
      do @(posedge clock); while (!req_tready);
      apply_to_schedule(op, kind, due, now, elapsed);
   endtask

   // Pick a due-like value: mostly small (ties and wrap), some full range, some near the top.
   function automatic logic [DUE_W-1:0] pick_cycle();
      case ($urandom_range(3))
         0, 1:    pick_cycle = DUE_W'($urandom_range(255));
         2:       pick_cycle = $urandom;
         default: pick_cycle = 32'hFFFF_FF00 | DUE_W'($urandom_range(255));
      endcase
   endfunction

   task automatic random_request();
      int                r;
      func_type          op;
      logic [KIND_W-1:0] kind;
      logic [DUE_W-1:0]  elapsed;
      r = $urandom_range(99);
      if (r < 42)      op = FUNC_INSERT;
      else if (r < 62) op = FUNC_CANCEL;
      else if (r < 90) op = FUNC_QUERY;
      else             op = FUNC_FRAME_END;
      // favor a few kinds so cancel and query hit often
      kind    = ($urandom_range(3) == 0) ? KIND_W'($urandom_range(15))
                                         : KIND_W'($urandom_range(3));
      elapsed = $urandom_range(1) ? DUE_W'($urandom_range(63)) : DUE_W'($urandom);
      send_request(op, kind, pick_cycle(), pick_cycle(), elapsed);
   endtask

   task automatic note_mismatch(string field, logic [DUE_W-1:0] want, logic [DUE_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %s: expected %h, got %h", field, want, got);
   endtask

   // Response side: check each accepted response against the oldest prediction,
   // then decide readiness for the next cycle (long hold-off first, else random).
   always @(posedge clock) begin
      queue_report_type got;
      queue_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status     = rsp_tuser;
         got.remaining  = rsp_tdata[31:0];
         got.head_valid = rsp_tdata[32];
         got.head_kind  = rsp_tdata[36:33];
         got.head_due   = rsp_tdata[68:37];
         got.occupancy  = rsp_tdata[73:69];
         if (reports_in_flight.size() == 0) begin
            note_mismatch("unexpected response", '0, got.remaining);
         end else begin
            want = reports_in_flight.pop_front();
            if (got.status != want.status)
               note_mismatch("status", DUE_W'(want.status), DUE_W'(got.status));
            if (got.remaining != want.remaining)
               note_mismatch("remaining", want.remaining, got.remaining);
            if (got.head_valid != want.head_valid)
               note_mismatch("head_valid", DUE_W'(want.head_valid), DUE_W'(got.head_valid));
            if (got.head_kind != want.head_kind)
               note_mismatch("head_kind", DUE_W'(want.head_kind), DUE_W'(got.head_kind));
            if (got.head_due != want.head_due)
               note_mismatch("head_due", want.head_due, got.head_due);
            if (got.occupancy != want.occupancy)
               note_mismatch("occupancy", DUE_W'(want.occupancy), DUE_W'(got.occupancy));
         end
      end
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Empty queue: query, cancel and frame end with nothing pending, then the lowest event.
   task automatic test_empty_queue();
      send_request(FUNC_QUERY, 4'd0, 32'd0, 32'd0, 32'd0);
      send_request(FUNC_CANCEL, 4'd15, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_request(FUNC_FRAME_END, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_request(FUNC_INSERT, 4'd0, 32'd0, 32'd0, 32'd0);
   endtask

   // Ordering: top due cycle, equal due cycles in arrival order, query answers incl. wrap.
   task automatic test_ordering_and_ties();
      send_request(FUNC_INSERT, 4'd15, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_request(FUNC_INSERT, 4'd3, 32'd100, 32'd0, 32'd0);
      send_request(FUNC_INSERT, 4'd5, 32'd100, 32'd0, 32'd0);
      send_request(FUNC_QUERY, 4'd5, 32'd0, 32'd40, 32'd0);
      send_request(FUNC_QUERY, 4'd15, 32'd0, 32'hFFFF_FFFF, 32'd0);
      send_request(FUNC_QUERY, 4'd9, 32'd0, 32'd7, 32'd0);
      send_request(FUNC_QUERY, 4'd0, 32'd0, 32'd1, 32'd0);
   endtask

   // Full queue: fill to DEPTH, drop one, wrap at frame end, cancel a repeated kind.
   task automatic test_full_queue();
      int i;
      for (i = 0; sched_count < DEPTH; i++)
         send_request(FUNC_INSERT, KIND_W'(4 + i % 4), DUE_W'(50 + 37 * i), 32'd0, 32'd0);
      send_request(FUNC_INSERT, 4'd10, 32'd1, 32'd0, 32'd0);
      send_request(FUNC_FRAME_END, 4'd0, 32'd0, 32'd0, 32'd200);
      send_request(FUNC_CANCEL, 4'd5, 32'd0, 32'd0, 32'd0);
   endtask

   task automatic test_random_phase(int send_pct, int recv_pct);
      int n;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (n = 0; n < PHASE_ITEMS; n++) random_request();
   endtask

   // Back-pressure: hold the response side off while requests keep coming.
   task automatic test_output_stall();
      int n;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_left = 300;
      for (n = 0; n < 40; n++) random_request();
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: errors");
      $finish;
   end

   initial begin
      send_idle_pct = 28;
      recv_idle_pct = 77;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_ordering_and_ties();
      test_full_queue();
      test_random_phase(28, 77);
      test_random_phase(77, 28);
      test_random_phase(0, 0);
      test_output_stall();

      // drain: drop valid, wait for every response, then allow the longest walk
      req_tvalid <= 1'b0;
      while (reports_in_flight.size() != 0) @(posedge clock);
      repeat (DEPTH + 20) @(posedge clock);

      if (mismatches == 0 && reports_in_flight.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
